// File: hw/rtl/mmkv_pkg.sv
`timescale 1ns / 1ps

package mmkv_pkg;

  localparam int DefCapacity = 64;
  localparam int DataW       = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_SCAN
  } mmkv_state_t;

  localparam logic FuncAppend = 1'b0;
  localparam logic FuncSearch = 1'b1;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr;     // capture the appended pair
    logic srch;   // compare against the search key, load scan stage
    logic shift;  // scan stage takes the neighbor's scan stage
  } mmkv_cell_ctl_t;

endpackage

// File: hw/rtl/multi_match_key_value_store_core.sv
`timescale 1ns / 1ps

// Append-only key/value store built as a row of CAPACITY cells, cell 0 holding
// the oldest pair. An append is accepted in ST_IDLE and its acknowledgement is
// loaded into the output register from ST_ACK; a full store drops the pair and
// flags full_res. A search compares the key in every cell in the accept cycle,
// then shifts the match flags and values toward cell 0 one cell per cycle
// while the output register is free (out_stall can hold it). Matches come out
// in insertion order, the final one with last set; a search that finds nothing
// returns one result with found clear. One request is in work at a time;
// in_stall is high until its last result is in the output register.

module multi_match_key_value_store_core import mmkv_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic signed [DataW-1:0] in_key,
  input  logic signed [DataW-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_is_search,
  output logic signed [DataW-1:0] out_found_value,
  output logic                    out_found,
  output logic                    out_full_res,
  output logic                    out_last
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  mmkv_state_t state_r, state_nxt;

  logic [CntW-1:0]         fill_r;
  logic [CntW-1:0]         cnt_r;
  logic                    full_r;
  logic                    pend_valid_r, pend_valid_nxt;
  logic signed [DataW-1:0] pend_value_r, pend_value_nxt;

  logic                    out_valid_r;
  logic                    out_is_search_r, out_is_search_nxt;
  logic signed [DataW-1:0] out_found_value_r, out_found_value_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_full_res_r, out_full_res_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_load;

  logic in_accept;
  logic out_free;
  logic full_now;
  logic append_go;
  logic search_go;
  logic shift_en;

  logic                    hit_w  [CAPACITY];
  logic signed [DataW-1:0] sval_w [CAPACITY];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full_now  = (fill_r == CntW'(CAPACITY));
  assign append_go = in_accept && (in_func == FuncAppend) && !full_now;
  assign search_go = in_accept && (in_func == FuncSearch);

  // cell row: scan data moves toward cell 0, the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mmkv_cell_ctl_t          ctl;
    logic                    nb_hit;
    logic signed [DataW-1:0] nb_value;

    assign ctl.wr    = append_go && (fill_r[IdxW-1:0] == IdxW'(i));
    assign ctl.srch  = search_go;
    assign ctl.shift = shift_en;

    if (i == CAPACITY - 1) begin : g_tail
      assign nb_hit   = 1'b0;
      assign nb_value = '0;
    end else begin : g_mid
      assign nb_hit   = hit_w[i+1];
      assign nb_value = sval_w[i+1];
    end

    mmkv_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_key     (in_key),
      .wr_value   (in_value),
      .srch_key   (in_key),
      .nb_hit     (nb_hit),
      .nb_value   (nb_value),
      .hit        (hit_w[i]),
      .scan_value (sval_w[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_func == FuncSearch) ? ST_SCAN : ST_ACK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_free && (cnt_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  // a match is held back in the pending register so the final one can carry last
  always_comb begin
    out_load            = 1'b0;
    shift_en            = 1'b0;
    out_is_search_nxt   = 1'b0;
    out_found_value_nxt = '0;
    out_found_nxt       = 1'b0;
    out_full_res_nxt    = 1'b0;
    out_last_nxt        = 1'b0;
    pend_valid_nxt      = pend_valid_r;
    pend_value_nxt      = pend_value_r;
    case (state_r)
      ST_IDLE: begin
        pend_valid_nxt = 1'b0;
      end
      ST_ACK: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_full_res_nxt = full_r;
          out_last_nxt     = 1'b1;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (cnt_r == '0) begin
            out_load            = 1'b1;
            out_is_search_nxt   = 1'b1;
            out_found_nxt       = pend_valid_r;
            out_found_value_nxt = pend_valid_r ? pend_value_r : '0;
            out_last_nxt        = 1'b1;
          end else begin
            shift_en = 1'b1;
            if (hit_w[0]) begin
              pend_valid_nxt = 1'b1;
              pend_value_nxt = sval_w[0];
              if (pend_valid_r) begin
                out_load            = 1'b1;
                out_is_search_nxt   = 1'b1;
                out_found_nxt       = 1'b1;
                out_found_value_nxt = pend_value_r;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      cnt_r        <= '0;
      full_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (append_go) begin
        fill_r <= fill_r + CntW'(1);
      end
      if (in_accept) begin
        full_r <= full_now;
      end
      if (search_go) begin
        cnt_r <= fill_r;
      end else if (shift_en) begin
        cnt_r <= cnt_r - CntW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_value_r <= pend_value_nxt;
    if (out_load) begin
      out_is_search_r   <= out_is_search_nxt;
      out_found_value_r <= out_found_value_nxt;
      out_found_r       <= out_found_nxt;
      out_full_res_r    <= out_full_res_nxt;
      out_last_r        <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_search   = out_is_search_r;
  assign out_found_value = out_found_value_r;
  assign out_found       = out_found_r;
  assign out_full_res    = out_full_res_r;
  assign out_last        = out_last_r;

endmodule

// File: hw/rtl/mmkv_cell.sv
`timescale 1ns / 1ps

module mmkv_cell import mmkv_pkg::*; (
  input  logic                    clk,
  input  mmkv_cell_ctl_t          ctl,
  input  logic signed [DataW-1:0] wr_key,
  input  logic signed [DataW-1:0] wr_value,
  input  logic signed [DataW-1:0] srch_key,
  input  logic                    nb_hit,
  input  logic signed [DataW-1:0] nb_value,
  output logic                    hit,
  output logic signed [DataW-1:0] scan_value
);

  logic signed [DataW-1:0] key_r;
  logic signed [DataW-1:0] value_r;
  logic                    hit_r;
  logic signed [DataW-1:0] sval_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      key_r   <= wr_key;
      value_r <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.srch) begin
      hit_r  <= (key_r == srch_key);
      sval_r <= value_r;
    end else if (ctl.shift) begin
      hit_r  <= nb_hit;
      sval_r <= nb_value;
    end
  end

  assign hit        = hit_r;
  assign scan_value = sval_r;

endmodule
